>>> hdl/cdis_pkg.sv
// ----------------------------------------------------------------------------
// cdis_pkg
// Shared types and constants for the CBOR data item skipper.
// ----------------------------------------------------------------------------
package cdis_pkg;

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_DONE    = 3'd1,
    ST_OVERRUN = 3'd2,
    ST_INTENC  = 3'd3,
    ST_UNSUP   = 3'd4,
    ST_DEEP    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_HEAD    = 2'd0,
    PH_ARG     = 2'd1,
    PH_STR     = 2'd2,
    PH_DISCARD = 2'd3
  } phase_t;

  localparam logic [2:0] MT_UINT   = 3'd0;
  localparam logic [2:0] MT_NINT   = 3'd1;
  localparam logic [2:0] MT_BYTES  = 3'd2;
  localparam logic [2:0] MT_TEXT   = 3'd3;
  localparam logic [2:0] MT_ARRAY  = 3'd4;
  localparam logic [2:0] MT_MAP    = 3'd5;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  localparam logic [4:0] AI_ARG_MIN  = 5'd24;
  localparam logic [4:0] AI_RESERVED = 5'd28;
  localparam logic [7:0] NULL_BYTE   = 8'hF6;

  localparam int VAL_W = 64;
  localparam int LEN_W = 16;

endpackage

>>> hdl/cdis_ram.sv
// ----------------------------------------------------------------------------
// cdis_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module cdis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/cbor_data_item_skipper_top.sv
// ----------------------------------------------------------------------------
// cbor_data_item_skipper_top
// Byte-serial CBOR item skipper with a RAM-backed nesting count stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel data_valid/data_ready carries one buffer byte per item,
//   with buffer_end set on the last byte of the buffer. Output channel
//   result_valid/result_ready gives one result item (status, item_length)
//   for every accepted byte, in order.
//   The result is registered at the edge that takes the byte, unless the
//   byte closes a container that has an enclosing one: then the input is
//   held in FSM_POP for each such closed container, each a RAM read of the
//   next enclosing count (the innermost count sits in a register, the rest
//   of the stack in RAM), and the result is registered when the walk up the
//   stack ends. Otherwise one byte is taken per cycle, while the output
//   register is empty or being emptied.
//   An output register parts the two channels: a new byte is taken while the
//   previous result is being consumed; a stalled receiver holds data_ready
//   low once the output register is full.
//   Reset (rst, synchronous) returns to awaiting a head byte with an empty
//   stack; the RAM needs no clearing, entries are written before they are
//   read.
// ----------------------------------------------------------------------------
module cbor_data_item_skipper_top #(
  parameter int NEST_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [15:0] item_length
);

  import cdis_pkg::*;

  localparam int LW = $clog2(NEST_DEPTH + 1);
  localparam int AW = $clog2(NEST_DEPTH);

  typedef enum logic {FSM_IN, FSM_POP} fsm_t;

  fsm_t              fsm, fsm_next;
  phase_t            phase, phase_next;
  logic [3:0]        arg_left, arg_left_next;
  logic [VAL_W-1:0]  arg_val, arg_val_next;
  logic [2:0]        held_major, held_major_next;
  logic [VAL_W-1:0]  str_left, str_left_next;
  logic [LW-1:0]     level, level_next;
  logic [VAL_W-1:0]  top_count, top_count_next;
  logic [LEN_W-1:0]  bytes_seen, bytes_seen_next;
  logic              last_q, last_q_next;
  logic              out_valid, out_valid_next;
  status_t           out_status, out_status_next;
  logic [LEN_W-1:0]  out_len, out_len_next;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  logic [LW-1:0]     lvl_m1, lvl_m2;
  logic [LEN_W-1:0]  bs_inc;
  logic [2:0]        major;
  logic [4:0]        info;

  cdis_ram #(
    .WIDTH(VAL_W),
    .DEPTH(NEST_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign data_ready   = (fsm == FSM_IN) && (!out_valid || result_ready);
  assign result_valid = out_valid;
  assign status       = out_status;
  assign item_length  = out_len;

  assign lvl_m1 = level - LW'(1);
  assign lvl_m2 = level - LW'(2);
  assign bs_inc = (bytes_seen != {LEN_W{1'b1}}) ? bytes_seen + LEN_W'(1) : bytes_seen;
  assign major  = data_byte[7:5];
  assign info   = data_byte[4:0];

  always_comb begin
    logic             fin;
    logic             go_pop;
    logic             elem;
    logic             act;
    logic [2:0]       act_major;
    logic [VAL_W-1:0] act_val;
    logic [VAL_W-1:0] cnt;
    logic [VAL_W-1:0] top_dec;
    logic [VAL_W-1:0] str_dec;
    logic [3:0]       arg_dec;
    logic             flast;
    logic [LEN_W-1:0] flen;
    status_t          fstat;

    fsm_next        = fsm;
    phase_next      = phase;
    arg_left_next   = arg_left;
    arg_val_next    = arg_val;
    held_major_next = held_major;
    str_left_next   = str_left;
    level_next      = level;
    top_count_next  = top_count;
    bytes_seen_next = bytes_seen;
    last_q_next     = last_q;
    out_valid_next  = out_valid && !result_ready;
    out_status_next = out_status;
    out_len_next    = out_len;

    ram_we    = 1'b0;
    ram_waddr = lvl_m1[AW-1:0];
    ram_wdata = top_count;
    ram_re    = 1'b0;
    ram_raddr = lvl_m2[AW-1:0];

    fin       = 1'b0;
    go_pop    = 1'b0;
    elem      = 1'b0;
    act       = 1'b0;
    act_major = held_major;
    act_val   = arg_val;
    cnt       = '0;
    top_dec   = top_count - VAL_W'(1);
    str_dec   = str_left - VAL_W'(str_left != '0);
    arg_dec   = arg_left - 4'(arg_left != 4'd0);
    flast     = buffer_end;
    flen      = bs_inc;
    fstat     = ST_BUSY;

    unique case (fsm)
      FSM_IN: begin
        if (data_valid && data_ready) begin
          last_q_next = buffer_end;
          if (phase == PH_DISCARD) begin
            out_valid_next  = 1'b1;
            out_status_next = ST_BUSY;
            out_len_next    = '0;
            if (buffer_end) begin
              phase_next = PH_HEAD;
            end
          end else begin
            bytes_seen_next = bs_inc;
            fin             = 1'b1;
            case (phase)
              PH_HEAD: begin
                if (major == MT_SIMPLE) begin
                  if (data_byte == NULL_BYTE) begin
                    elem = 1'b1;
                  end else begin
                    fstat = ST_UNSUP;
                  end
                end else if (info >= AI_RESERVED) begin
                  fstat = ST_INTENC;
                end else if (info < AI_ARG_MIN) begin
                  act       = 1'b1;
                  act_major = major;
                  act_val   = VAL_W'(info);
                end else begin
                  held_major_next = major;
                  arg_val_next    = '0;
                  arg_left_next   = 4'b0001 << info[1:0];
                  phase_next      = PH_ARG;
                end
              end
              PH_ARG: begin
                arg_val_next  = {arg_val[VAL_W-9:0], data_byte};
                arg_left_next = arg_dec;
                if (arg_dec == 4'd0) begin
                  act       = 1'b1;
                  act_major = held_major;
                  act_val   = {arg_val[VAL_W-9:0], data_byte};
                end
              end
              default: begin
                str_left_next = str_dec;
                if (str_dec == '0) begin
                  elem = 1'b1;
                end
              end
            endcase

            if (act) begin
              case (act_major) inside
                MT_UINT, MT_NINT: begin
                  elem = 1'b1;
                end
                MT_BYTES, MT_TEXT: begin
                  if (act_val == '0) begin
                    elem = 1'b1;
                  end else begin
                    str_left_next = act_val;
                    phase_next    = PH_STR;
                  end
                end
                MT_ARRAY, MT_MAP: begin
                  cnt = (act_major == MT_MAP) ? {act_val[VAL_W-2:0], 1'b0} : act_val;
                  if (cnt == '0) begin
                    elem = 1'b1;
                  end else if (level >= LW'(NEST_DEPTH)) begin
                    fstat = ST_DEEP;
                  end else begin
                    ram_we         = (level != '0);
                    top_count_next = cnt;
                    level_next     = level + LW'(1);
                    phase_next     = PH_HEAD;
                  end
                end
                default: begin
                  fstat = ST_UNSUP;
                end
              endcase
            end

            if (elem) begin
              phase_next = PH_HEAD;
              if (level == '0) begin
                fstat = ST_DONE;
              end else if (top_dec != '0) begin
                top_count_next = top_dec;
              end else begin
                level_next = lvl_m1;
                if (lvl_m1 == '0) begin
                  fstat = ST_DONE;
                end else begin
                  go_pop = 1'b1;
                end
              end
            end
          end
        end
      end
      FSM_POP: begin
        fin     = 1'b1;
        flast   = last_q;
        flen    = bytes_seen;
        top_dec = ram_rdata - VAL_W'(1);
        if (top_dec != '0) begin
          top_count_next = top_dec;
        end else begin
          level_next = lvl_m1;
          if (lvl_m1 == '0) begin
            fstat = ST_DONE;
          end else begin
            go_pop = 1'b1;
          end
        end
      end
      default: begin
        fsm_next = FSM_IN;
      end
    endcase

    if (go_pop) begin
      // next enclosing count comes from the registered RAM read, used in FSM_POP
      ram_re   = 1'b1;
      fsm_next = FSM_POP;
    end else if (fin) begin
      if (fstat == ST_BUSY && flast) begin
        fstat = ST_OVERRUN;
      end
      out_valid_next  = 1'b1;
      out_status_next = fstat;
      out_len_next    = flen;
      fsm_next        = FSM_IN;
      if (fstat != ST_BUSY) begin
        phase_next      = PH_HEAD;
        level_next      = '0;
        bytes_seen_next = '0;
        if (fstat != ST_DONE && !flast) begin
          phase_next = PH_DISCARD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= FSM_IN;
      phase      <= PH_HEAD;
      arg_left   <= '0;
      arg_val    <= '0;
      held_major <= '0;
      str_left   <= '0;
      level      <= '0;
      bytes_seen <= '0;
      out_valid  <= 1'b0;
    end else begin
      fsm        <= fsm_next;
      phase      <= phase_next;
      arg_left   <= arg_left_next;
      arg_val    <= arg_val_next;
      held_major <= held_major_next;
      str_left   <= str_left_next;
      level      <= level_next;
      bytes_seen <= bytes_seen_next;
      out_valid  <= out_valid_next;
    end
    top_count  <= top_count_next;
    last_q     <= last_q_next;
    out_status <= out_status_next;
    out_len    <= out_len_next;
  end

endmodule

>>> tb/cdis_checker.sv
// ----------------------------------------------------------------------------
// cdis_checker
// Watches both channels of the CBOR item skipper. Every byte taken at the
// input is run through a local model of the skip walk (argument collection,
// string bodies, count stack, error discarding). The status and item_length
// it gives are queued, and each result item at the output is compared with
// the oldest one queued.
// ----------------------------------------------------------------------------
module cdis_checker #(
  parameter int NEST_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        buffer_end,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [2:0]  status,
  input  logic [15:0] item_length,
  output int          fail_count,
  output int          outstanding
);
  import cdis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     st;
    logic [15:0] len;
  } skip_result_t;

  skip_result_t due_results[$];
  skip_result_t want;
  skip_result_t fresh;

  phase_t      walk_phase;
  logic [3:0]  arg_left;
  logic [63:0] arg_val;
  logic [2:0]  held_major;
  logic [63:0] str_left;
  logic [63:0] open_counts [NEST_DEPTH];
  int          depth_now;
  logic [15:0] item_bytes;

  function automatic void clear_walk();
    walk_phase = PH_HEAD;
    arg_left   = '0;
    arg_val    = '0;
    held_major = '0;
    str_left   = '0;
    depth_now  = 0;
    item_bytes = '0;
  endfunction

  // one element finished: close every container it completes
  function automatic status_t close_element();
    walk_phase = PH_HEAD;
    while (depth_now > 0 && depth_now <= NEST_DEPTH) begin
      open_counts[depth_now-1] = open_counts[depth_now-1] - 64'd1;
      if (open_counts[depth_now-1] != 64'd0) return ST_BUSY;
      depth_now = depth_now - 1;
    end
    return ST_DONE;
  endfunction

  function automatic status_t finish_head(logic [2:0] major, logic [63:0] value);
    logic [63:0] count;
    case (major)
      MT_UINT, MT_NINT: begin
        return close_element();
      end
      MT_BYTES, MT_TEXT: begin
        if (value == 64'd0) return close_element();
        str_left   = value;
        walk_phase = PH_STR;
        return ST_BUSY;
      end
      MT_ARRAY, MT_MAP: begin
        count = (major == MT_MAP) ? (value << 1) : value;
        if (count == 64'd0) return close_element();
        if (depth_now >= NEST_DEPTH) return ST_DEEP;
        open_counts[depth_now] = count;
        depth_now  = depth_now + 1;
        walk_phase = PH_HEAD;
        return ST_BUSY;
      end
      default: begin
        return ST_UNSUP;
      end
    endcase
  endfunction

  function automatic void walk_byte(input logic [7:0] b, input logic last,
                                    output status_t st, output logic [15:0] len);
    logic [2:0] major;
    logic [4:0] info;
    if (walk_phase == PH_DISCARD) begin
      if (last) walk_phase = PH_HEAD;
      st  = ST_BUSY;
      len = '0;
      return;
    end
    if (item_bytes != 16'hFFFF) item_bytes = item_bytes + 16'd1;
    st = ST_BUSY;
    case (walk_phase)
      PH_HEAD: begin
        major = b[7:5];
        info  = b[4:0];
        if (major == MT_SIMPLE) begin
          st = (b == NULL_BYTE) ? close_element() : ST_UNSUP;
        end else if (info >= AI_RESERVED) begin
          st = ST_INTENC;
        end else if (info < AI_ARG_MIN) begin
          st = finish_head(major, 64'(info));
        end else begin
          held_major = major;
          arg_val    = '0;
          arg_left   = 4'(1 << (info - AI_ARG_MIN));
          walk_phase = PH_ARG;
        end
      end
      PH_ARG: begin
        arg_val = {arg_val[55:0], b};
        if (arg_left != 4'd0) arg_left = arg_left - 4'd1;
        if (arg_left == 4'd0) st = finish_head(held_major, arg_val);
      end
      default: begin
        if (str_left != 64'd0) str_left = str_left - 64'd1;
        if (str_left == 64'd0) st = close_element();
      end
    endcase
    if (st == ST_BUSY && last) st = ST_OVERRUN;
    len = item_bytes;
    if (st != ST_BUSY) begin
      clear_walk();
      if (st != ST_DONE && !last) walk_phase = PH_DISCARD;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_walk();
      due_results.delete();
      outstanding <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $error("result with no byte pending: status %0d item_length %0d",
                 status, item_length);
          fail_count = fail_count + 1;
        end else begin
          want = due_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count = fail_count + 1;
          end
          if (item_length !== want.len) begin
            $error("item_length: expected %0d, got %0d", want.len, item_length);
            fail_count = fail_count + 1;
          end
        end
      end
      if (data_valid && data_ready) begin
        walk_byte(data_byte, buffer_end, fresh.st, fresh.len);
        due_results.push_back(fresh);
      end
      outstanding <= due_results.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the CBOR item skipper: a few hand-made buffers for the edge
// cases, then random buffers of well-formed items, truncated and corrupted
// buffers, noise and deep nesting, under four idling patterns. The checker
// does all comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import cdis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEST_DEPTH  = 16;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 220;

  logic        clk;
  logic        rst          = 1'b1;
  logic        data_valid   = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte    = 8'h00;
  logic        buffer_end   = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] item_length;

  int fail_count;
  int outstanding;
  int gap_pct       = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int quiet_cycles  = 0;

  cbor_data_item_skipper_top #(.NEST_DEPTH(NEST_DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .buffer_end   (buffer_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .item_length  (item_length)
  );

  cdis_checker #(.NEST_DEPTH(NEST_DEPTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_ready   (data_ready),
    .data_byte    (data_byte),
    .buffer_end   (buffer_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .item_length  (item_length),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        holds_done = holds_done + 1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic offer_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      data_valid <= 1'b0;
      @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    buffer_end <= last;
    do @(posedge clk); while (!data_ready);
  endtask

  task automatic offer_buffer(input logic [7:0] q[$]);
    foreach (q[i]) offer_byte(q[i], i == q.size() - 1);
  endtask

  task automatic drain();
    data_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic void append_head(ref logic [7:0] q[$], input logic [2:0] major,
                                      input logic [63:0] val, input int form);
    int nb;
    if (form == 0) begin
      q.push_back({major, val[4:0]});
    end else begin
      nb = 1 << (form - 1);
      q.push_back({major, 5'(AI_ARG_MIN + form - 1)});
      for (int i = nb - 1; i >= 0; i--) q.push_back(val[8*i +: 8]);
    end
  endfunction

  // count or length in any encoding wide enough to hold it
  function automatic void append_count(ref logic [7:0] q[$], input logic [2:0] major,
                                       input int n);
    int minf;
    minf = (n < 24) ? 0 : (n < 256) ? 1 : (n < 65536) ? 2 : 3;
    append_head(q, major, 64'(n), $urandom_range(4, minf));
  endfunction

  function automatic void append_item(ref logic [7:0] q[$], input int max_nest);
    int         open_left[$];
    int         kind;
    int         n;
    int         form;
    logic [63:0] val;
    bit         finished;
    finished = 1'b0;
    while (!finished) begin
      kind = (open_left.size() >= max_nest) ? $urandom_range(0, 2) : $urandom_range(0, 4);
      n = 0;
      case (kind)
        0: begin
          form = $urandom_range(0, 4);
          val  = (form == 0) ? 64'($urandom_range(0, 23)) : {$urandom, $urandom};
          append_head(q, 3'($urandom_range(0, 1)), val, form);
        end
        1: begin
          form = $urandom_range(0, 5);
          append_count(q, 3'($urandom_range(2, 3)), form);
          repeat (form) q.push_back(8'($urandom));
        end
        2: q.push_back(NULL_BYTE);
        3: begin
          n = $urandom_range(0, 3);
          append_count(q, MT_ARRAY, n);
        end
        default: begin
          n = $urandom_range(0, 2);
          append_count(q, MT_MAP, n);
          n = 2 * n;
        end
      endcase
      if (n != 0) begin
        open_left.push_back(n);
      end else begin
        finished = 1'b1;
        while (open_left.size() != 0) begin
          open_left[$] = open_left[$] - 1;
          if (open_left[$] != 0) begin
            finished = 1'b0;
            break;
          end
          void'(open_left.pop_back());
        end
      end
    end
  endfunction

  function automatic void build_buffer(ref logic [7:0] q[$]);
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) begin
      repeat ($urandom_range(1, 3)) append_item(q, $urandom_range(1, 4));
    end else if (sel < 70) begin
      append_item(q, $urandom_range(1, 4));
      if (q.size() > 1) repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
    end else if (sel < 80) begin
      repeat (2) append_item(q, $urandom_range(1, 3));
      q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
    end else if (sel < 90) begin
      repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
    end else begin
      // nesting around the stack limit
      repeat ($urandom_range(NEST_DEPTH - 1, NEST_DEPTH + 1)) q.push_back(8'h81);
      q.push_back(8'h00);
    end
  endfunction

  initial begin
    logic [7:0] buf_q[$];
    int         sent;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    buf_q = {8'h00};                                                offer_buffer(buf_q);
    buf_q = {8'h1B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
             8'hFF, 8'hFF, 8'hFF, 8'hFF};                           offer_buffer(buf_q);
    buf_q = {8'h37};                                                offer_buffer(buf_q);
    buf_q = {8'hF6};                                                offer_buffer(buf_q);
    buf_q = {8'h1C};                                                offer_buffer(buf_q);
    buf_q = {8'hFF, 8'h00};                                         offer_buffer(buf_q);
    buf_q = {8'hC1};                                                offer_buffer(buf_q);
    buf_q = {8'hD8, 8'h20, 8'h01};                                  offer_buffer(buf_q);
    buf_q = {8'h40, 8'h60, 8'h80, 8'hA0};                           offer_buffer(buf_q);
    buf_q = {8'hBB, 8'h80, 8'h00, 8'h00, 8'h00,
             8'h00, 8'h00, 8'h00, 8'h00};                           offer_buffer(buf_q);
    buf_q = {8'h82, 8'h01};                                         offer_buffer(buf_q);
    buf_q = {8'h62, 8'h61, 8'h62, 8'h3F};                           offer_buffer(buf_q);

    // long receiver hold-off while the sender keeps offering
    hold_requests <= hold_requests + 1;
    sent = 0;
    while (sent < 40) begin
      buf_q.delete();
      build_buffer(buf_q);
      offer_buffer(buf_q);
      sent = sent + buf_q.size();
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        buf_q.delete();
        build_buffer(buf_q);
        offer_buffer(buf_q);
        sent = sent + buf_q.size();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
